### hdl/rfme_pkg.sv
// ----------------------------------------------------------------------------
// rfme_pkg: shared types and constants of the rectangle fill / mono expand
// blitter. Field widths, default geometry, command and status codes, FSM states.
// ----------------------------------------------------------------------------
package rfme_pkg;

  // field widths of the command and result words
  localparam int ACC_W  = 18;
  localparam int DATA_W = 16;
  localparam int DIM_W  = 10;
  localparam int ROP_W  = 16;

  // default framebuffer geometry
  localparam int FB_BYTES_DEF    = 262144;
  localparam int PITCH_BYTES_DEF = 1024;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_FILL   = 2'd2,
    OP_EXPAND = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_ROP     = 2'd3
  } st_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DEC,
    S_SPAN,
    S_END,
    S_CHECK,
    S_RD0,
    S_RD1,
    S_RD2,
    S_WR0,
    S_WR1,
    S_FILL,
    S_XRD,
    S_XLD,
    S_XPIX,
    S_DONE
  } state_t;

endpackage

### hdl/rect_fill_mono_expand_blitter.sv
// ----------------------------------------------------------------------------
// rect_fill_mono_expand_blitter: 2D drawing engine around a byte-wide frame store
// Runs halfword CPU reads/writes, solid rectangle fills and 1-bpp mask expands
// on an internal synchronous memory; one status word comes back per command.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_stall  | opcode, offsets, size, colour, rop
//  out_    | output    | out_valid/out_stall| read_data, status
//
//  Flow: a command is taken in S_IDLE only; one command is in work at a time.
//  Read steps S_DEC, S_RD0, S_RD1, S_RD2, S_DONE; write S_DEC, S_WR0, S_WR1, S_DONE;
//  fill and expand first pass S_SPAN, S_END, S_CHECK. The single byte write
//  port of the frame store paces fill and expand: at most one byte lands per cycle.
//  Reset: synchronous, active low. After reset a clearing pass zeroes the store,
//  one byte a cycle, with in_stall held high.
//  Stalls: a finished status waits in the output register while the next
//  command is accepted; the engine holds in S_DONE only if that register is full.
//
module rect_fill_mono_expand_blitter #(
  parameter int FB_BYTES    = rfme_pkg::FB_BYTES_DEF,
  parameter int PITCH_BYTES = rfme_pkg::PITCH_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // command channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [rfme_pkg::ACC_W-1:0]  in_access_offset,
  input  logic [rfme_pkg::DATA_W-1:0] in_write_data,
  input  logic [rfme_pkg::ACC_W-1:0]  in_dest_offset,
  input  logic [rfme_pkg::ACC_W-1:0]  in_mask_offset,
  input  logic [rfme_pkg::DIM_W-1:0]  in_rect_width,
  input  logic [rfme_pkg::DIM_W-1:0]  in_rect_height,
  input  logic [rfme_pkg::DATA_W-1:0] in_colour,
  input  logic [rfme_pkg::ROP_W-1:0]  in_raster_op,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rfme_pkg::DATA_W-1:0] out_read_data,
  output logic [1:0]                  out_status
);
  import rfme_pkg::*;

  // Address width of the store, and a compare width that holds any end of span
  localparam int AW       = $clog2(FB_BYTES);
  localparam int SPAN_MAX = (2 ** ACC_W) + ((2 ** DIM_W) - 1) * PITCH_BYTES + 2 * (2 ** DIM_W);
  localparam int TOP      = (SPAN_MAX > FB_BYTES) ? SPAN_MAX : FB_BYTES;
  localparam int CW       = $clog2(TOP) + 1;

  localparam logic [CW-1:0] FB_C    = CW'(FB_BYTES);
  localparam logic [CW-1:0] PITCH_C = CW'(PITCH_BYTES);
  localparam logic [CW-1:0] LAST_C  = CW'(FB_BYTES - 1);

  // ---------------------------------------------------------------- state
  state_t state_r, state_nxt;

  // captured command
  op_t               op_r;
  logic [ACC_W-1:0]  acc_r;
  logic [DATA_W-1:0] wdat_r;
  logic [ACC_W-1:0]  dst_r;
  logic [ACC_W-1:0]  src_r;
  logic [DIM_W-1:0]  w_r;
  logic [DIM_W-1:0]  h_r;
  logic [DATA_W-1:0] col_r;
  logic              rop_nz_r;

  // span check
  logic [CW-1:0] dspan_r, sspan_r, dend_r, send_r;

  // walk pointers and counters
  logic [CW-1:0]    ptr_r;    // destination byte (also the clear pointer)
  logic [CW-1:0]    drow_r;   // start of current destination row
  logic [CW-1:0]    mptr_r;   // current mask byte
  logic [CW-1:0]    mrow_r;   // start of current mask row
  logic [DIM_W-1:0] x_r, y_r;
  logic             ph_r;     // byte phase inside a pixel: 0 low, 1 high
  logic [7:0]       mbits_r;  // mask byte, shifted left one bit per pixel
  logic [7:0]       lo_r;

  // result
  st_t               st_r;
  logic [DATA_W-1:0] rdata_r;
  logic              out_valid_r;
  st_t               out_status_r;
  logic [DATA_W-1:0] out_rdata_r;

  // frame store
  logic [7:0]    fb_mem [FB_BYTES];
  logic [7:0]    mem_rdata_r;
  logic          mem_we;
  logic [CW-1:0] waddr_w;
  logic [CW-1:0] raddr_w;
  logic [7:0]    wbyte;

  // ---------------------------------------------------------------- decode
  logic          accept;
  logic          out_free;
  logic          load_out;
  logic [CW-1:0] acc_w;
  logic          acc_oob;
  logic          zero_sz;
  logic          dst_oob;
  logic          src_oob;
  logic          ovl;
  logic          x_last;
  logic          y_last;
  logic          pix_done;
  logic [7:0]    mbytes;
  logic [DIM_W:0] wsum;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == S_DONE) && out_free;

  assign acc_w    = CW'(acc_r);
  assign acc_oob  = (acc_w + CW'(2)) > FB_C;
  assign zero_sz  = (w_r == '0) || (h_r == '0);
  assign dst_oob  = dend_r > FB_C;
  assign src_oob  = send_r > FB_C;
  // half-open spans [src, send) and [dst, dend) share a byte
  assign ovl      = (CW'(src_r) < dend_r) && (CW'(dst_r) < send_r);
  assign x_last   = (x_r == w_r - DIM_W'(1));
  assign y_last   = (y_r == h_r - DIM_W'(1));
  assign pix_done = !mbits_r[7] || ph_r;
  assign wsum     = {1'b0, w_r} + (DIM_W + 1)'(7);
  assign mbytes   = 8'(wsum >> 3);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (ptr_r == LAST_C) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_DEC;
      end
      S_DEC: begin
        case (op_r)
          OP_READ:   state_nxt = acc_oob ? S_DONE : S_RD0;
          OP_WRITE:  state_nxt = acc_oob ? S_DONE : S_WR0;
          OP_FILL:   state_nxt = zero_sz ? S_DONE : S_SPAN;
          OP_EXPAND: state_nxt = (rop_nz_r || zero_sz) ? S_DONE : S_SPAN;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_SPAN:  state_nxt = S_END;
      S_END:   state_nxt = S_CHECK;
      S_CHECK: begin
        if (op_r == OP_FILL) begin
          state_nxt = dst_oob ? S_DONE : S_FILL;
        end else begin
          state_nxt = (dst_oob || src_oob || ovl) ? S_DONE : S_XRD;
        end
      end
      S_RD0:   state_nxt = S_RD1;
      S_RD1:   state_nxt = S_RD2;
      S_RD2:   state_nxt = S_DONE;
      S_WR0:   state_nxt = S_WR1;
      S_WR1:   state_nxt = S_DONE;
      S_FILL: begin
        if (ph_r && x_last && y_last) state_nxt = S_DONE;
      end
      S_XRD:   state_nxt = S_XLD;
      S_XLD:   state_nxt = S_XPIX;
      S_XPIX: begin
        if (pix_done) begin
          if (x_last) state_nxt = y_last ? S_DONE : S_XRD;
          else if (x_r[2:0] == 3'd7) state_nxt = S_XRD;
        end
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- memory controls
  always_comb begin
    mem_we  = 1'b0;
    waddr_w = ptr_r;
    wbyte   = ph_r ? col_r[15:8] : col_r[7:0];
    raddr_w = mptr_r;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        wbyte  = 8'h00;
      end
      S_RD0: raddr_w = acc_w;
      S_RD1: raddr_w = acc_w + CW'(1);
      S_WR0: begin
        mem_we  = 1'b1;
        waddr_w = acc_w;
        wbyte   = wdat_r[7:0];
      end
      S_WR1: begin
        mem_we  = 1'b1;
        waddr_w = acc_w + CW'(1);
        wbyte   = wdat_r[15:8];
      end
      S_FILL: mem_we = 1'b1;
      S_XPIX: mem_we = mbits_r[7];
      default: mem_we = 1'b0;
    endcase
  end

  // Mask and destination never share a byte once the check passes, so the
  // mask read needs no forwarding from the pixel writes.
  always_ff @(posedge clk) begin
    if (mem_we) fb_mem[waddr_w[AW-1:0]] <= wbyte;
    mem_rdata_r <= fb_mem[raddr_w[AW-1:0]];
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // hold the finished status until the output side takes it
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= st_r;
      out_rdata_r  <= rdata_r;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      case (state_r)
        S_CLEAR: ptr_r <= ptr_r + CW'(1);
        S_IDLE: begin
          if (accept) begin
            op_r     <= op_t'(in_opcode);
            acc_r    <= in_access_offset;
            wdat_r   <= in_write_data;
            dst_r    <= in_dest_offset;
            src_r    <= in_mask_offset;
            w_r      <= in_rect_width;
            h_r      <= in_rect_height;
            col_r    <= in_colour;
            rop_nz_r <= (in_raster_op != '0);
            st_r     <= ST_OK;
            rdata_r  <= '0;
            ptr_r    <= CW'(in_dest_offset);
            drow_r   <= CW'(in_dest_offset);
            mptr_r   <= CW'(in_mask_offset);
            mrow_r   <= CW'(in_mask_offset);
            x_r      <= '0;
            y_r      <= '0;
            ph_r     <= 1'b0;
          end
        end
        S_DEC: begin
          if ((op_r == OP_READ || op_r == OP_WRITE) && acc_oob) st_r <= ST_RANGE;
          if (op_r == OP_EXPAND && rop_nz_r) st_r <= ST_ROP;
        end
        S_SPAN: begin
          dspan_r <= CW'(h_r - DIM_W'(1)) * PITCH_C + (CW'(w_r) << 1);
          sspan_r <= CW'(h_r - DIM_W'(1)) * PITCH_C + CW'(mbytes);
        end
        S_END: begin
          dend_r <= CW'(dst_r) + dspan_r;
          send_r <= CW'(src_r) + sspan_r;
        end
        S_CHECK: begin
          // range comes before overlap
          if (dst_oob || (op_r == OP_EXPAND && src_oob)) st_r <= ST_RANGE;
          else if (op_r == OP_EXPAND && ovl) st_r <= ST_OVERLAP;
        end
        S_RD1: lo_r <= mem_rdata_r;
        S_RD2: rdata_r <= {mem_rdata_r, lo_r};
        S_FILL: begin
          ph_r  <= ~ph_r;
          ptr_r <= ptr_r + CW'(1);
          if (ph_r) begin
            if (x_last) begin
              // advance to the next row
              x_r    <= '0;
              y_r    <= y_r + DIM_W'(1);
              drow_r <= drow_r + PITCH_C;
              ptr_r  <= drow_r + PITCH_C;
            end else begin
              x_r <= x_r + DIM_W'(1);
            end
          end
        end
        S_XLD: mbits_r <= mem_rdata_r;
        S_XPIX: begin
          if (mbits_r[7]) begin
            ph_r  <= ~ph_r;
            ptr_r <= ptr_r + CW'(1);
          end else begin
            // skip the pixel, destination unchanged
            ptr_r <= ptr_r + CW'(2);
          end
          if (pix_done) begin
            mbits_r <= mbits_r << 1;
            x_r     <= x_r + DIM_W'(1);
            if (x_last) begin
              x_r    <= '0;
              y_r    <= y_r + DIM_W'(1);
              drow_r <= drow_r + PITCH_C;
              ptr_r  <= drow_r + PITCH_C;
              mrow_r <= mrow_r + PITCH_C;
              mptr_r <= mrow_r + PITCH_C;
            end else if (x_r[2:0] == 3'd7) begin
              mptr_r <= mptr_r + CW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- ports
  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_rdata_r;
  assign out_status    = out_status_r;

  // ---------------------------------------------------------------- checks
`ifndef ASSERT_OFF
  // every store write lands inside the frame store
  a_waddr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (waddr_w < FB_C))
    else $error("frame store write beyond end");

  // pixel writes of an expand never hit the mask byte being walked
  a_expand_no_alias: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_XPIX && mem_we) |-> (ptr_r != mptr_r))
    else $error("expand writes over its own mask");

  // only an ok read returns data
  a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (load_out && (op_r != OP_READ || st_r != ST_OK)) |-> (rdata_r == '0))
    else $error("read data on a command that returns none");

  // no store writes once an error status is set
  a_no_write_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r != S_CLEAR) |-> (st_r == ST_OK))
    else $error("store written by a failed command");
`endif

endmodule
